// File: rtl/bitmap_page_frame_allocator_unit_macros.svh
// Assertion macros for the bitmap page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bpfa_pkg.sv
// Shared types and constants of the bitmap page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;

	localparam int unsigned BITMAP_WORDS = 32;
	localparam int unsigned WORD_BITS    = 32;
	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned FREE_W       = 11;
	localparam int unsigned PAGE_SHIFT   = 12;
	localparam logic [WORD_BITS-1:0] MSB_MASK   = 32'h8000_0000;
	localparam logic [ADDR_W-1:0]    END_RESET  = 32'h0040_0000;

	typedef enum logic [0:0] {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_RANGE   = 2'd2,
		ST_ALREADY = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_START = 1'b0,
		CFG_END   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		status_t           status;
		logic [FREE_W-1:0] free_pages;
	} rsp_t;

	// Result of the first-free search over one bitmap word.
	typedef struct packed {
		logic       found;
		logic [4:0] bit_idx;
	} ffs_res_t;

endpackage
`default_nettype wire

// File: rtl/bpfa_ffs.sv
// First free frame search over one bitmap word, MSB is the lowest frame.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_ffs (
	input  wire logic [bpfa_pkg::WORD_BITS-1:0] word,
	output bpfa_pkg::ffs_res_t                  res
);

	logic [bpfa_pkg::WORD_BITS-1:0] avail;
	logic [4:0]                     cnt;

	// leading-zero count of the free mask, binary search in five steps
	always_comb begin
		avail = ~word;
		cnt   = '0;
		if (avail[31:16] == '0) begin
			avail  = avail << 16;
			cnt[4] = 1'b1;
		end
		if (avail[31:24] == '0) begin
			avail  = avail << 8;
			cnt[3] = 1'b1;
		end
		if (avail[31:28] == '0) begin
			avail  = avail << 4;
			cnt[2] = 1'b1;
		end
		if (avail[31:30] == '0) begin
			avail  = avail << 2;
			cnt[1] = 1'b1;
		end
		if (!avail[31]) begin
			cnt[0] = 1'b1;
		end
		res.found   = (word != '1);
		res.bit_idx = cnt;
	end

endmodule
`default_nettype wire

// File: rtl/bpfa_mem.sv
// Bitmap word memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_mem #(
	parameter int unsigned BITMAP_WORDS = bpfa_pkg::BITMAP_WORDS,
	parameter int unsigned WORD_AW      = 5
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [WORD_AW-1:0]             waddr,
	input  wire logic [bpfa_pkg::WORD_BITS-1:0] wdata,
	input  wire logic                           re,
	input  wire logic [WORD_AW-1:0]             raddr,
	output logic      [bpfa_pkg::WORD_BITS-1:0] rdata
);

	logic [bpfa_pkg::WORD_BITS-1:0] mem [BITMAP_WORDS];
	logic [bpfa_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: rtl/bitmap_page_frame_allocator_unit.sv
// Top level of the first-fit bitmap page frame allocator.
// Alloc scans the bitmap words in order from word 0 (1 to BITMAP_WORDS words scanned), then
//   goes to S_DONE; free passes through S_FREE_CHK, S_FREE_UPD and S_DONE. A stalled earlier
//   result holds S_DONE. A new request is taken only after the previous result is loaded.
// Reset: async, active low; then a clearing pass over all BITMAP_WORDS words zeroes the bitmap,
//   with req_stall high. Configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_frame_allocator_unit_macros.svh"
module bitmap_page_frame_allocator_unit #(
	parameter int unsigned BITMAP_WORDS = bpfa_pkg::BITMAP_WORDS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write port
	input  wire logic                        cfg_we,
	input  wire bpfa_pkg::cfg_reg_t          cfg_index,
	input  wire logic [bpfa_pkg::ADDR_W-1:0] cfg_data,
	// request channel
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire bpfa_pkg::req_t              req,
	// response channel
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output bpfa_pkg::rsp_t                   rsp
);

	localparam int unsigned WordAw      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int unsigned FrameW      = WordAw + 5;
	localparam int unsigned TotalFrames = BITMAP_WORDS * bpfa_pkg::WORD_BITS;
	localparam int unsigned AddrW       = bpfa_pkg::ADDR_W;
	localparam int unsigned WordBits    = bpfa_pkg::WORD_BITS;
	localparam int unsigned FreeW       = bpfa_pkg::FREE_W;
	localparam int unsigned PAGE_SH     = bpfa_pkg::PAGE_SHIFT;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		S_CLEAR    = 6'b000001,
		S_IDLE     = 6'b000010,
		S_SCAN     = 6'b000100,
		S_FREE_CHK = 6'b001000,
		S_FREE_UPD = 6'b010000,
		S_DONE     = 6'b100000
	} state_t;

	state_t                   state_q, state_d;
	logic [WordAw-1:0]        idx_q, idx_d;
	logic [AddrW-1:0]         addr_q, addr_d;
	logic [FrameW-1:0]        frame_q, frame_d;
	bpfa_pkg::status_t        status_q, status_d;
	logic [FreeW-1:0]         free_q, free_d;
	logic [AddrW-1:0]         start_q, end_q;
	bpfa_pkg::rsp_t           rsp_q;
	logic                     rsp_valid_q;

	// memory port
	logic                     mem_we, mem_re;
	logic [WordAw-1:0]        mem_waddr, mem_raddr;
	logic [WordBits-1:0]      mem_wdata, mem_rdata;

	bpfa_pkg::ffs_res_t       ffs;
	logic                     req_fire, load_rsp, last_word, in_range;
	logic [AddrW-1:0]         offset, page_addr;
	logic [AddrW-1:0]         off_ext;
	logic [AddrW-PAGE_SH-1:0] off_frame;
	logic [WordBits-1:0]      free_mask;

	bpfa_mem #(
		.BITMAP_WORDS(BITMAP_WORDS),
		.WORD_AW     (WordAw)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// the search unit sees the word read in the previous cycle
	bpfa_ffs u_ffs (
		.word(mem_rdata),
		.res (ffs)
	);

	assign req_fire  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign last_word = (idx_q == WordAw'(BITMAP_WORDS - 1));

	// free path: range check on the latched address
	assign offset    = addr_q - start_q;
	assign off_frame = offset[AddrW-1:PAGE_SH];
	assign off_ext   = {{PAGE_SH{1'b0}}, off_frame};
	assign in_range  = (addr_q >= start_q) && (addr_q < end_q) &&
	                   (off_ext < AddrW'(TotalFrames));
	assign free_mask = bpfa_pkg::MSB_MASK >> frame_q[4:0];

	// frame number to absolute address, wraps at 2^32
	assign page_addr = start_q + (AddrW'(frame_q) << PAGE_SH);

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		addr_d    = addr_q;
		frame_d   = frame_q;
		status_d  = status_q;
		free_d    = free_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		load_rsp  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (last_word) begin
					idx_d   = '0;
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (req_fire) begin
					addr_d = req.address;
					if (req.kind == bpfa_pkg::KIND_ALLOC) begin
						mem_re    = 1'b1;
						mem_raddr = '0;
						idx_d     = '0;
						state_d   = S_SCAN;
					end else begin
						state_d = S_FREE_CHK;
					end
				end
			end
			S_SCAN: begin
				// check word idx_q, prefetch idx_q + 1
				if (ffs.found) begin
					frame_d   = {idx_q, ffs.bit_idx};
					mem_we    = 1'b1;
					mem_wdata = mem_rdata | (bpfa_pkg::MSB_MASK >> ffs.bit_idx);
					free_d    = free_q - 1'b1;
					status_d  = bpfa_pkg::ST_OK;
					state_d   = S_DONE;
				end else if (last_word) begin
					status_d = bpfa_pkg::ST_NOMEM;
					state_d  = S_DONE;
				end else begin
					idx_d     = idx_q + 1'b1;
					mem_re    = 1'b1;
					mem_raddr = idx_q + 1'b1;
				end
			end
			S_FREE_CHK: begin
				if (in_range) begin
					frame_d   = off_frame[FrameW-1:0];
					mem_re    = 1'b1;
					mem_raddr = off_frame[FrameW-1:5];
					state_d   = S_FREE_UPD;
				end else begin
					status_d = bpfa_pkg::ST_RANGE;
					state_d  = S_DONE;
				end
			end
			S_FREE_UPD: begin
				mem_waddr = frame_q[FrameW-1:5];
				if ((mem_rdata & free_mask) != '0) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata & ~free_mask;
					free_d    = free_q + 1'b1;
					status_d  = bpfa_pkg::ST_OK;
				end else begin
					status_d = bpfa_pkg::ST_ALREADY;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				// wait for the output register to free up
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			free_q      <= FreeW'(TotalFrames);
			start_q     <= '0;
			end_q       <= bpfa_pkg::END_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			free_q  <= free_d;
			if (cfg_we) begin
				unique case (cfg_index)
					bpfa_pkg::CFG_START: start_q <= cfg_data;
					bpfa_pkg::CFG_END:   end_q   <= cfg_data;
					default:             end_q   <= end_q;
				endcase
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		addr_q   <= addr_d;
		frame_q  <= frame_d;
		status_q <= status_d;
		if (load_rsp) begin
			rsp_q.page_address <= (status_q == bpfa_pkg::ST_OK) ? page_addr : '0;
			rsp_q.status       <= status_q;
			rsp_q.free_pages   <= free_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// error results never carry an address
	`BPFA_ASSERT_NOW(a_err_addr_zero, clk, arst_n,
		rsp_valid && (rsp.status != bpfa_pkg::ST_OK), rsp.page_address == '0, "error with address")
	// one item at a time: busy right after a transfer
	`BPFA_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_fire, req_stall, "accepted while busy")
	// no request taken during the clearing pass
	`BPFA_ASSERT_NOW(a_clear_stalls, clk, arst_n, state_q == S_CLEAR, req_stall, "req during clear")

endmodule
`default_nettype wire
